[design/tcba_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, codes and the microcode ROM of the temperature averaging core.
package tcba_pkg;

	localparam int RAW_W       = 20;
	localparam int CAL_W       = 16;
	localparam int OUT_W       = 32;
	// A compensated sample always lies in [-2^17, 2^17).
	localparam int SAMPLE_W    = 18;
	localparam int MUL_A_W     = 22;
	localparam int MUL_B_W     = 17;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int PART_W      = 22;
	localparam int FINE_W      = 23;
	localparam int SCALED_W    = 26;
	localparam int ROUND_BIAS  = 128;
	localparam int GROUP_DIVISOR = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int PC_W        = 4;

	typedef logic signed [MUL_A_W-1:0]  tcba_mula_t;
	typedef logic signed [MUL_B_W-1:0]  tcba_mulb_t;
	typedef logic signed [FINE_W-1:0]   tcba_fine_t;
	typedef logic signed [SCALED_W-1:0] tcba_scaled_t;
	typedef logic signed [OUT_W-1:0]    tcba_word_t;
	typedef logic [PC_W-1:0]            tcba_pc_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_T1 = 2'd0,
		REG_CAL_T2 = 2'd1,
		REG_CAL_T3 = 2'd2
	} tcba_reg_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_MUL2,
		OP_MUL3,
		OP_SAMP,
		OP_ACC,
		OP_DIV,
		OP_MEAN,
		OP_AVG,
		OP_OUT
	} tcba_op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_REQ,
		COND_NOT_BLOCK_END,
		COND_NOT_GROUP_END,
		COND_OUT_BUSY
	} tcba_cond_t;

	typedef struct packed {
		tcba_op_t   op;
		tcba_cond_t cond;
		tcba_pc_t   target;
		logic       ret;
	} tcba_ctl_t;

	typedef struct packed {
		logic no_req;
		logic not_block_end;
		logic not_group_end;
		logic out_busy;
	} tcba_flags_t;

	typedef struct packed {
		logic not_block_end;
		logic not_group_end;
	} tcba_stat_t;

	typedef struct packed {
		logic        [CAL_W-1:0] t1;
		logic signed [CAL_W-1:0] t2;
		logic signed [CAL_W-1:0] t3;
	} tcba_cal_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       done;
		logic signed [SAMPLE_W-1:0] mean;
		logic                       upd;
		logic signed [SAMPLE_W-1:0] avg;
	} tcba_res_t;

	localparam tcba_pc_t STEP_IDLE = 4'd0;
	localparam tcba_pc_t STEP_MUL2 = 4'd1;
	localparam tcba_pc_t STEP_MUL3 = 4'd2;
	localparam tcba_pc_t STEP_SAMP = 4'd3;
	localparam tcba_pc_t STEP_ACC  = 4'd4;
	localparam tcba_pc_t STEP_BDIV = 4'd5;
	localparam tcba_pc_t STEP_MEAN = 4'd6;
	localparam tcba_pc_t STEP_GDIV = 4'd7;
	localparam tcba_pc_t STEP_AVG  = 4'd8;
	localparam tcba_pc_t STEP_OUT  = 4'd9;

	// Microcode ROM. A taken condition jumps to target; otherwise the step
	// counter advances, or returns to idle when ret is set.
	function automatic tcba_ctl_t ucode(input tcba_pc_t pc);
		tcba_ctl_t w;
		begin
			w.op     = OP_IDLE;
			w.cond   = COND_NEVER;
			w.target = STEP_IDLE;
			w.ret    = 1'b0;
			unique case (pc)
				STEP_IDLE: begin
					w.cond = COND_NO_REQ;
					w.target = STEP_IDLE;
				end
				STEP_MUL2: w.op = OP_MUL2;
				STEP_MUL3: w.op = OP_MUL3;
				STEP_SAMP: w.op = OP_SAMP;
				STEP_ACC: begin
					w.op = OP_ACC;
					w.cond = COND_NOT_BLOCK_END;
					w.target = STEP_OUT;
				end
				STEP_BDIV: w.op = OP_DIV;
				STEP_MEAN: begin
					w.op = OP_MEAN;
					w.cond = COND_NOT_GROUP_END;
					w.target = STEP_OUT;
				end
				STEP_GDIV: w.op = OP_DIV;
				STEP_AVG: w.op = OP_AVG;
				STEP_OUT: begin
					w.op = OP_OUT;
					w.cond = COND_OUT_BUSY;
					w.target = STEP_OUT;
					w.ret = 1'b1;
				end
				default: w.ret = 1'b1;
			endcase
			return w;
		end
	endfunction

endpackage

[design/tcba_seq.sv]
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module tcba_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcba_pkg::tcba_flags_t flags,
	output tcba_pkg::tcba_ctl_t   ctl
);

	tcba_pkg::tcba_pc_t pc_q;
	tcba_pkg::tcba_pc_t pc_next;
	logic               jump;

	assign ctl = tcba_pkg::ucode(pc_q);

	always_comb begin
		unique case (ctl.cond)
			tcba_pkg::COND_NEVER:         jump = 1'b0;
			tcba_pkg::COND_NO_REQ:        jump = flags.no_req;
			tcba_pkg::COND_NOT_BLOCK_END: jump = flags.not_block_end;
			tcba_pkg::COND_NOT_GROUP_END: jump = flags.not_group_end;
			tcba_pkg::COND_OUT_BUSY:      jump = flags.out_busy;
			default:                      jump = 1'b0;
		endcase
	end

	always_comb begin
		if (jump) begin
			pc_next = ctl.target;
		end else if (ctl.ret) begin
			pc_next = tcba_pkg::STEP_IDLE;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tcba_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[design/tcba_dp.sv]
`timescale 1ns / 1ps
// Datapath: shared multiplier, compensation, block and group accumulators, reciprocal divider.
module tcba_dp #(
	parameter int SAMPLES_PER_BLOCK = 64,
	parameter int BLOCKS_PER_GROUP  = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcba_pkg::tcba_ctl_t               ctl,
	input  logic                              in_accept,
	input  logic [tcba_pkg::RAW_W-1:0]        raw_temperature,
	input  tcba_pkg::tcba_cal_t               cal,
	output tcba_pkg::tcba_stat_t              stat,
	output tcba_pkg::tcba_res_t               res
);

	localparam int SW      = tcba_pkg::SAMPLE_W;
	localparam int CNT_W   = $clog2(SAMPLES_PER_BLOCK);
	localparam int IDX_W   = (BLOCKS_PER_GROUP > 1) ? $clog2(BLOCKS_PER_GROUP) : 1;
	localparam int SUM_W   = SW + $clog2(SAMPLES_PER_BLOCK);
	localparam int MSUM_W  = SW + $clog2(BLOCKS_PER_GROUP);
	localparam int DIV_W   = (SUM_W > MSUM_W) ? SUM_W : MSUM_W;
	localparam int RCP_W   = DIV_W + 1;
	localparam int RPROD_W = DIV_W + RCP_W;
	localparam int BLK_SH  = DIV_W + $clog2(SAMPLES_PER_BLOCK);
	localparam int GRP_SH  = DIV_W + $clog2(tcba_pkg::GROUP_DIVISOR);
	// Rounded-up reciprocals; the quotient is exact for every dividend below 2^DIV_W.
	localparam logic [RCP_W-1:0] BLK_RCP = RCP_W'(((longint'(1) << BLK_SH) +
		longint'(SAMPLES_PER_BLOCK) - 1) / longint'(SAMPLES_PER_BLOCK));
	localparam logic [RCP_W-1:0] GRP_RCP = RCP_W'(((longint'(1) << GRP_SH) +
		longint'(tcba_pkg::GROUP_DIVISOR) - 1) / longint'(tcba_pkg::GROUP_DIVISOR));

	// Compensation registers.
	logic [15:0]                          adc_hi_q;
	logic signed [tcba_pkg::PROD_W-1:0]   prod_q;
	logic signed [tcba_pkg::PART_W-1:0]   part1_q;
	logic signed [SW-1:0]                 sample_q;

	// Accumulator state.
	logic [CNT_W-1:0]                     cnt_q;
	logic [IDX_W-1:0]                     idx_q;
	logic signed [SUM_W-1:0]              block_sum_q;
	logic signed [MSUM_W-1:0]             msum_q;
	logic signed [SW-1:0]                 held_q;
	logic signed [SW-1:0]                 mean_q;
	logic                                 done_q;
	logic                                 upd_q;

	// Divider registers.
	logic [DIV_W-1:0]                     div_quo_q;
	logic                                 div_neg_q;
	logic                                 div_grp_q;

	logic signed [17:0]                   d1;
	logic signed [16:0]                   d2;
	tcba_pkg::tcba_mula_t                 mul_a;
	tcba_pkg::tcba_mulb_t                 mul_b;
	logic signed [tcba_pkg::PROD_W-1:0]   product;
	logic                                 mul_en;
	logic signed [tcba_pkg::PART_W-1:0]   part2;
	tcba_pkg::tcba_fine_t                 fine;
	tcba_pkg::tcba_scaled_t               fine_ext;
	tcba_pkg::tcba_scaled_t               scaled;

	logic                                 block_end;
	logic                                 group_end;
	logic signed [SUM_W-1:0]              sum_new;
	logic [SUM_W-1:0]                     sum_mag;
	logic signed [MSUM_W-1:0]             msum_new;
	logic [MSUM_W-1:0]                    msum_mag;
	logic [SW-1:0]                        quo_lo;
	logic signed [SW-1:0]                 quo_signed;
	logic [RCP_W-1:0]                     rcp;
	logic [RPROD_W-1:0]                   rcp_prod;

	// Operand selection for the one shared multiplier.
	assign d1 = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
	assign d2 = $signed({1'b0, adc_hi_q}) - $signed({1'b0, cal.t1});

	always_comb begin
		case (ctl.op)
			tcba_pkg::OP_MUL2: begin
				mul_a = tcba_pkg::tcba_mula_t'(d2);
				mul_b = d2;
			end
			tcba_pkg::OP_MUL3: begin
				// The square is never negative, so its upper bits form a positive operand.
				mul_a = $signed(prod_q[33:12]);
				mul_b = tcba_pkg::tcba_mulb_t'(cal.t3);
			end
			default: begin
				mul_a = tcba_pkg::tcba_mula_t'(d1);
				mul_b = tcba_pkg::tcba_mulb_t'(cal.t2);
			end
		endcase
	end

	assign product = mul_a * mul_b;
	assign mul_en  = (ctl.op == tcba_pkg::OP_IDLE && in_accept) ||
	                 ctl.op == tcba_pkg::OP_MUL2 || ctl.op == tcba_pkg::OP_MUL3;

	// Fine temperature, then times five plus rounding bias, shifted down by eight.
	assign part2    = $signed(prod_q[35:14]);
	assign fine     = tcba_pkg::tcba_fine_t'(part1_q) + tcba_pkg::tcba_fine_t'(part2);
	assign fine_ext = tcba_pkg::tcba_scaled_t'(fine);
	assign scaled   = $signed({fine_ext[tcba_pkg::SCALED_W-3:0], 2'b00}) + fine_ext +
	                  tcba_pkg::tcba_scaled_t'(tcba_pkg::ROUND_BIAS);

	assign block_end = (cnt_q == CNT_W'(SAMPLES_PER_BLOCK - 1));
	assign group_end = (idx_q == IDX_W'(BLOCKS_PER_GROUP - 1));
	assign sum_new   = block_sum_q + SUM_W'(sample_q);
	assign sum_mag   = sum_new[SUM_W-1] ? -sum_new : sum_new;

	assign quo_lo     = div_quo_q[SW-1:0];
	assign quo_signed = div_neg_q ? -$signed(quo_lo) : $signed(quo_lo);
	assign msum_new   = msum_q + MSUM_W'(quo_signed);
	assign msum_mag   = msum_new[MSUM_W-1] ? -msum_new : msum_new;

	// The magnitude is divided by multiplying with a rounded-up reciprocal and
	// dropping the low bits; the sign is put back afterwards.
	assign rcp      = div_grp_q ? GRP_RCP : BLK_RCP;
	assign rcp_prod = div_quo_q * rcp;

	assign stat.not_block_end = !block_end;
	assign stat.not_group_end = !group_end;

	assign res.sample = sample_q;
	assign res.done   = done_q;
	assign res.mean   = mean_q;
	assign res.upd    = upd_q;
	assign res.avg    = held_q;

	always_ff @(posedge clk) begin
		if (ctl.op == tcba_pkg::OP_IDLE && in_accept) begin
			adc_hi_q <= raw_temperature[19:4];
		end
		if (mul_en) begin
			prod_q <= product;
		end
		if (ctl.op == tcba_pkg::OP_MUL2) begin
			part1_q <= $signed(prod_q[32:11]);
		end
		if (ctl.op == tcba_pkg::OP_SAMP) begin
			sample_q <= $signed(scaled[tcba_pkg::SCALED_W-1:8]);
		end

		case (ctl.op)
			tcba_pkg::OP_ACC: begin
				done_q <= block_end;
				upd_q  <= 1'b0;
				mean_q <= '0;
				div_quo_q <= DIV_W'(sum_mag);
				div_neg_q <= sum_new[SUM_W-1];
				div_grp_q <= 1'b0;
			end
			tcba_pkg::OP_DIV: begin
				div_quo_q <= div_grp_q ? rcp_prod[GRP_SH +: DIV_W] : rcp_prod[BLK_SH +: DIV_W];
			end
			tcba_pkg::OP_MEAN: begin
				mean_q <= quo_signed;
				upd_q  <= group_end;
				div_quo_q <= DIV_W'(msum_mag);
				div_neg_q <= msum_new[MSUM_W-1];
				div_grp_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			block_sum_q <= '0;
			msum_q      <= '0;
			held_q      <= '0;
		end else begin
			case (ctl.op)
				tcba_pkg::OP_ACC: begin
					if (block_end) begin
						cnt_q       <= '0;
						block_sum_q <= '0;
					end else begin
						cnt_q       <= cnt_q + 1'b1;
						block_sum_q <= sum_new;
					end
				end
				tcba_pkg::OP_MEAN: begin
					if (group_end) begin
						idx_q  <= '0;
						msum_q <= '0;
					end else begin
						idx_q  <= idx_q + 1'b1;
						msum_q <= msum_new;
					end
				end
				tcba_pkg::OP_AVG: held_q <= quo_signed;
				default: ;
			endcase
		end
	end

endmodule

[design/temp_compensate_and_block_average_core.sv]
`timescale 1ns / 1ps
// Top level: handshakes, calibration registers, output register, sequencer and datapath.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  raw_temperature
//   result    out        out_valid / out_stall temperature_centi, block_done, block_mean,
//                                             average_updated, average_deci
//   config    in         cfg_we               cfg_index, cfg_wdata
//
// From acceptance, a sample passes through a step for each of the three products that share
// one multiplier, then the steps to scale, accumulate and load the result, before the next
// request can be taken. A block end adds a step for the reciprocal division and one for
// the mean, and a group end adds the second division and the average. Reset clears the
// accumulators and the held average and loads the calibration defaults. A stalled result
// holds the sequencer in its output step; the next request is taken once the result
// register has been loaded.
module temp_compensate_and_block_average_core #(
	parameter int SAMPLES_PER_BLOCK = 64,
	parameter int BLOCKS_PER_GROUP  = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [tcba_pkg::RAW_W-1:0]            raw_temperature,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [tcba_pkg::OUT_W-1:0]     temperature_centi,
	output logic                                  block_done,
	output logic signed [tcba_pkg::OUT_W-1:0]     block_mean,
	output logic                                  average_updated,
	output logic signed [tcba_pkg::OUT_W-1:0]     average_deci,
	input  logic                                  cfg_we,
	input  logic [tcba_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tcba_pkg::CAL_W-1:0]            cfg_wdata
);

	tcba_pkg::tcba_ctl_t   ctl;
	tcba_pkg::tcba_flags_t flags;
	tcba_pkg::tcba_stat_t  stat;
	tcba_pkg::tcba_res_t   res;
	tcba_pkg::tcba_cal_t   cal_q;

	logic                  in_accept;
	logic                  out_busy;
	logic                  load_out;
	logic                  out_valid_q;
	tcba_pkg::tcba_word_t  temp_q;
	logic                  done_q;
	tcba_pkg::tcba_word_t  mean_q;
	logic                  upd_q;
	tcba_pkg::tcba_word_t  avg_q;

	assign in_stall  = (ctl.op != tcba_pkg::OP_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_busy  = out_valid_q && out_stall;
	assign load_out  = (ctl.op == tcba_pkg::OP_OUT) && !out_busy;

	assign flags.no_req        = !in_accept;
	assign flags.not_block_end = stat.not_block_end;
	assign flags.not_group_end = stat.not_group_end;
	assign flags.out_busy      = out_busy;

	tcba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	tcba_dp #(
		.SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
		.BLOCKS_PER_GROUP  (BLOCKS_PER_GROUP)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.in_accept       (in_accept),
		.raw_temperature (raw_temperature),
		.cal             (cal_q),
		.stat            (stat),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.t1 <= 16'd27504;
			cal_q.t2 <= 16'sd26435;
			cal_q.t3 <= -16'sd1000;
		end else if (cfg_we) begin
			unique case (tcba_pkg::tcba_reg_t'(cfg_index))
				tcba_pkg::REG_CAL_T1: cal_q.t1 <= cfg_wdata;
				tcba_pkg::REG_CAL_T2: cal_q.t2 <= $signed(cfg_wdata);
				tcba_pkg::REG_CAL_T3: cal_q.t3 <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			temp_q <= tcba_pkg::tcba_word_t'(res.sample);
			done_q <= res.done;
			mean_q <= tcba_pkg::tcba_word_t'(res.mean);
			upd_q  <= res.upd;
			avg_q  <= tcba_pkg::tcba_word_t'(res.avg);
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_q;
	assign block_done        = done_q;
	assign block_mean        = mean_q;
	assign average_updated   = upd_q;
	assign average_deci      = avg_q;

`ifndef SYNTHESIS
	// Only one sample is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("request accepted while a sample was still in work");

	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !block_done) |-> (block_mean == '0))
		else $error("block mean not zero outside a block end");

	a_group_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && average_updated) |-> block_done)
		else $error("group average updated without a block end");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid && out_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule
